/* src/bscl_pkg.sv */
// Package with constants, codes and arithmetic helpers for the bead-spring chain step block.
package bscl_pkg;

    localparam int BEAD_COUNT = 8;
    localparam int IDX_W      = (BEAD_COUNT > 1) ? $clog2(BEAD_COUNT) : 1;
    localparam int LAST_BEAD  = BEAD_COUNT - 1;

    localparam logic [15:0] SPRING_GAIN_RST = 16'd6554;
    localparam logic [15:0] NOISE_GAIN_RST  = 16'd29309;

    localparam int ACC_W = 53;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } t_opcode;

    typedef enum logic {
        CFG_SPRING_GAIN = 1'b0,
        CFG_NOISE_GAIN  = 1'b1
    } t_cfg_index;

    // Round half up to Q16.16 and clamp to the 32-bit range.
    function automatic logic signed [31:0] f_round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-17:0] q;
        logic signed [31:0] res;
        rnd = acc + ACC_W'(32768);
        q   = rnd[ACC_W-1:16];
        if (q > (ACC_W-16)'(64'sd2147483647)) begin
            res = 32'sh7fffffff;
        end else if (q < -(ACC_W-16)'(64'sd2147483648)) begin
            res = 32'sh80000000;
        end else begin
            res = q[31:0];
        end
        return res;
    endfunction

endpackage

/* src/bead_spring_chain_langevin_step_top.sv */
// Top level: bead-spring chain Langevin update over a two-read, one-write position memory.
//
// Input stream: s_axis_tuser is the opcode (load or advance), s_axis_tdata carries the
// bead index, load position and two noise samples. A load writes one bead and gives no
// result; an advance updates the next bead of the sweep and gives one result on m_axis,
// with m_axis_tlast set for the last bead of the chain.
// Items pass a four-stage pipeline: memory read, operand select and Laplacian,
// multiply, round/saturate with write-back into the output register. One item is
// taken per cycle while the output does not stall; an advance that needs a bead
// still being written by an older item in flight waits in the operand stage until
// that write lands.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr (0 spring gain,
// 1 noise gain). Write only while the block is idle; the block does not enforce this.
// Reset clears the pipeline, the sweep position, the left-neighbor register and sets the
// gains to their defaults; bead memory is undefined until loaded.
// When the receiver stalls, the output register holds and the pipeline freezes behind
// it; the operand stage can still take one item.
module bead_spring_chain_langevin_step_top
    import bscl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] bead_index, [34:3] load_x, [66:35] load_y, [82:67] noise_x,
    // [98:83] noise_y, [103:99] zero
    input  logic [103:0] s_axis_tdata,
    // [0] opcode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] bead_number, [34:3] new_x, [66:35] new_y, [71:67] zero
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata
);

    logic [15:0] r_spring_gain;
    logic [15:0] r_noise_gain;

    logic signed [31:0] r_mem_x [BEAD_COUNT];
    logic signed [31:0] r_mem_y [BEAD_COUNT];
    logic signed [31:0] r_rd_px, r_rd_py, r_rd_rx, r_rd_ry;

    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] n_pos;
    logic signed [31:0] r_prior_x, r_prior_y;

    // operand stage
    logic               r_s1_vld, r_s1_adv, r_s1_we, r_s1_last;
    logic [IDX_W-1:0]   r_s1_addr, r_s1_radr;
    logic signed [31:0] r_s1_ldx, r_s1_ldy;
    logic signed [15:0] r_s1_nzx, r_s1_nzy;
    logic               r_ovp, r_ovr;
    logic signed [31:0] r_ovp_x, r_ovp_y, r_ovr_x, r_ovr_y;

    // multiply stage
    logic               r_s2_vld, r_s2_adv, r_s2_we, r_s2_last;
    logic [IDX_W-1:0]   r_s2_addr;
    logic signed [31:0] r_s2_px, r_s2_py;
    logic signed [33:0] r_s2_lapx, r_s2_lapy;
    logic signed [15:0] r_s2_nzx, r_s2_nzy;

    // round stage
    logic               r_s3_vld, r_s3_adv, r_s3_we, r_s3_last;
    logic [IDX_W-1:0]   r_s3_addr;
    logic signed [31:0] r_s3_px, r_s3_py;
    logic signed [50:0] r_s3_spx, r_s3_spy;
    logic signed [32:0] r_s3_nnx, r_s3_nny;

    // output register
    logic               r_out_vld, r_out_last;
    logic [2:0]         r_out_num;
    logic signed [31:0] r_out_x, r_out_y;

    logic               en, hazard, s1_move, in_acc, wr;
    logic               in_adv, in_we;
    logic [IDX_W-1:0]   in_idx, pos_next_adr;
    logic signed [31:0] p_x, p_y, rt_x, rt_y, lf_x, lf_y;
    logic signed [31:0] new_x, new_y;
    logic signed [50:0] spx, spy;
    logic signed [32:0] nnx, nny;
    logic signed [ACC_W-1:0] accx, accy;

    function automatic logic f_hit(
        input logic             s2v,
        input logic             s2w,
        input logic [IDX_W-1:0] s2a,
        input logic             s3v,
        input logic             s3w,
        input logic [IDX_W-1:0] s3a,
        input logic [IDX_W-1:0] a
    );
        return (s2v && s2w && (s2a == a)) || (s3v && s3w && (s3a == a));
    endfunction

    assign en      = !r_out_vld || m_axis_tready;
    assign hazard  = r_s1_vld && r_s1_adv &&
                     (f_hit(r_s2_vld, r_s2_we, r_s2_addr, r_s3_vld, r_s3_we, r_s3_addr,
                            r_s1_addr) ||
                      (!r_s1_last &&
                       f_hit(r_s2_vld, r_s2_we, r_s2_addr, r_s3_vld, r_s3_we, r_s3_addr,
                             r_s1_radr)));
    assign s1_move = r_s1_vld && en && !hazard;
    assign s_axis_tready = !r_s1_vld || (en && !hazard);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign wr      = en && r_s3_vld && r_s3_we;

    assign in_adv       = (s_axis_tuser == OP_ADVANCE);
    assign in_idx       = in_adv ? r_pos : IDX_W'(s_axis_tdata[2:0]);
    assign in_we        = in_adv || (32'(s_axis_tdata[2:0]) < BEAD_COUNT);
    assign pos_next_adr = r_pos + IDX_W'(1);
    assign n_pos        = (r_pos == IDX_W'(LAST_BEAD)) ? '0 : pos_next_adr;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring_gain <= SPRING_GAIN_RST;
            r_noise_gain  <= NOISE_GAIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_SPRING_GAIN: r_spring_gain <= i_cfg_wdata;
                CFG_NOISE_GAIN:  r_noise_gain  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // position memory: two reads at transfer, one write-back
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_px <= r_mem_x[r_pos];
            r_rd_py <= r_mem_y[r_pos];
            r_rd_rx <= r_mem_x[pos_next_adr];
            r_rd_ry <= r_mem_y[pos_next_adr];
        end
        if (wr) begin
            r_mem_x[r_s3_addr] <= new_x;
            r_mem_y[r_s3_addr] <= new_y;
        end
    end

    // sweep position and left neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_prior_x <= '0;
            r_prior_y <= '0;
        end else begin
            if (in_acc && in_adv) begin
                r_pos <= n_pos;
            end
            if (s1_move && r_s1_adv) begin
                r_prior_x <= p_x;
                r_prior_y <= p_y;
            end
        end
    end

    // operand stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    // operand stage payload, with snoop of write-back
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_adv  <= in_adv;
            r_s1_we   <= in_we;
            r_s1_addr <= in_idx;
            r_s1_radr <= pos_next_adr;
            r_s1_last <= (r_pos == IDX_W'(LAST_BEAD));
            r_s1_ldx  <= s_axis_tdata[34:3];
            r_s1_ldy  <= s_axis_tdata[66:35];
            r_s1_nzx  <= s_axis_tdata[82:67];
            r_s1_nzy  <= s_axis_tdata[98:83];
            r_ovp     <= wr && (r_s3_addr == r_pos);
            r_ovr     <= wr && (r_s3_addr == pos_next_adr);
            r_ovp_x   <= new_x;
            r_ovp_y   <= new_y;
            r_ovr_x   <= new_x;
            r_ovr_y   <= new_y;
        end else begin
            if (wr && (r_s3_addr == r_s1_addr)) begin
                r_ovp   <= 1'b1;
                r_ovp_x <= new_x;
                r_ovp_y <= new_y;
            end
            if (wr && (r_s3_addr == r_s1_radr)) begin
                r_ovr   <= 1'b1;
                r_ovr_x <= new_x;
                r_ovr_y <= new_y;
            end
        end
    end

    always_comb begin
        p_x  = r_ovp ? r_ovp_x : r_rd_px;
        p_y  = r_ovp ? r_ovp_y : r_rd_py;
        rt_x = r_s1_last ? p_x : (r_ovr ? r_ovr_x : r_rd_rx);
        rt_y = r_s1_last ? p_y : (r_ovr ? r_ovr_y : r_rd_ry);
        lf_x = (r_s1_addr == '0) ? p_x : r_prior_x;
        lf_y = (r_s1_addr == '0) ? p_y : r_prior_y;
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld  <= s1_move;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld && r_s3_adv;
        end
    end

    assign spx = 51'(signed'({1'b0, r_spring_gain})) * 51'(r_s2_lapx);
    assign spy = 51'(signed'({1'b0, r_spring_gain})) * 51'(r_s2_lapy);
    assign nnx = 33'(signed'({1'b0, r_noise_gain})) * 33'(r_s2_nzx);
    assign nny = 33'(signed'({1'b0, r_noise_gain})) * 33'(r_s2_nzy);

    assign accx = (ACC_W'(r_s3_px) <<< 16) + ACC_W'(r_s3_spx) + (ACC_W'(r_s3_nnx) <<< 4);
    assign accy = (ACC_W'(r_s3_py) <<< 16) + ACC_W'(r_s3_spy) + (ACC_W'(r_s3_nny) <<< 4);
    assign new_x = r_s3_adv ? f_round_sat(accx) : r_s3_px;
    assign new_y = r_s3_adv ? f_round_sat(accy) : r_s3_py;

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_adv  <= r_s1_adv;
            r_s2_we   <= r_s1_we;
            r_s2_addr <= r_s1_addr;
            r_s2_last <= r_s1_last;
            r_s2_px   <= r_s1_adv ? p_x : r_s1_ldx;
            r_s2_py   <= r_s1_adv ? p_y : r_s1_ldy;
            r_s2_lapx <= 34'(lf_x) + 34'(rt_x) - (34'(p_x) <<< 1);
            r_s2_lapy <= 34'(lf_y) + 34'(rt_y) - (34'(p_y) <<< 1);
            r_s2_nzx  <= r_s1_nzx;
            r_s2_nzy  <= r_s1_nzy;

            r_s3_adv  <= r_s2_adv;
            r_s3_we   <= r_s2_we;
            r_s3_addr <= r_s2_addr;
            r_s3_last <= r_s2_last;
            r_s3_px   <= r_s2_px;
            r_s3_py   <= r_s2_py;
            r_s3_spx  <= spx;
            r_s3_spy  <= spy;
            r_s3_nnx  <= nnx;
            r_s3_nny  <= nny;

            r_out_num  <= 3'(r_s3_addr);
            r_out_x    <= new_x;
            r_out_y    <= new_y;
            r_out_last <= r_s3_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'd0, r_out_y, r_out_x, r_out_num};

    // an advance never leaves the operand stage past an older pending write to its beads
    a_no_raw : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_adv) |-> !(r_s3_vld && r_s3_we &&
            ((r_s3_addr == r_s1_addr) || (!r_s1_last && (r_s3_addr == r_s1_radr)))))
        else $error("advance left operand stage over a pending write");

    a_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) <= LAST_BEAD)
        else $error("sweep position out of range");

    a_out_from_adv : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_s3_vld && r_s3_adv))
        else $error("result without an advance");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_s3_vld) |=> r_s3_vld && $stable(r_s3_addr))
        else $error("round stage moved while output stalled");

endmodule
